// File: rtl/fv1rd_pkg.sv
`default_nettype none

package fv1rd_pkg;

  localparam int unsigned MaxRecords = 24;
  localparam int unsigned RecW       = 5;
  localparam int unsigned ClsW       = 2;
  localparam int unsigned NumCls     = 4;

  localparam logic ActHeader = 1'b0;
  localparam logic ActRecord = 1'b1;

  localparam logic [1:0] StHdrOk   = 2'd0;
  localparam logic [1:0] StHdrRej  = 2'd1;
  localparam logic [1:0] StRecOk   = 2'd2;
  localparam logic [1:0] StRecDrop = 2'd3;

  localparam logic [ClsW-1:0] ClsIcmp  = 2'd0;
  localparam logic [ClsW-1:0] ClsTcp   = 2'd1;
  localparam logic [ClsW-1:0] ClsUdp   = 2'd2;
  localparam logic [ClsW-1:0] ClsOther = 2'd3;

  localparam logic [7:0] ProtoIcmp = 8'd1;
  localparam logic [7:0] ProtoTcp  = 8'd6;
  localparam logic [7:0] ProtoUdp  = 8'd17;

  // ms = (ns >> 6) / 15625, done as multiply by reciprocal and shift
  localparam logic [9:0]  MsPerSec   = 10'd1000;
  localparam logic [26:0] NsDivMul   = 27'd70368745;
  localparam int unsigned NsDivShift = 40;
  localparam int unsigned SecsMsW    = 42;
  localparam int unsigned NanosMsW   = 13;

  typedef struct packed {
    logic        action;
    logic [15:0] record_count;
    logic [31:0] uptime_ms;
    logic [31:0] epoch_secs;
    logic [31:0] epoch_nanos;
    logic [31:0] first_uptime;
    logic [31:0] last_uptime;
    logic [31:0] packet_total;
    logic [31:0] octet_total;
    logic [7:0]  ip_protocol;
    logic [15:0] source_port;
    logic [15:0] dest_port;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [63:0] start_ms;
    logic [63:0] end_ms;
    logic [15:0] out_src_port;
    logic [15:0] out_dst_port;
    logic [1:0]  proto_class;
    logic [63:0] class_flows;
    logic [63:0] class_packets;
    logic [63:0] class_bytes;
    logic [63:0] all_flows;
    logic [63:0] all_packets;
    logic [63:0] all_bytes;
  } out_item_t;

  typedef struct packed {
    logic [63:0] flows;
    logic [63:0] packets;
    logic [63:0] bytes;
  } cnt_t;

  typedef struct packed {
    logic                valid;
    in_item_t            item;
    logic [ClsW-1:0]     cls;
    logic [SecsMsW-1:0]  secs_ms;
    logic [NanosMsW-1:0] nanos_ms;
  } front_t;

  function automatic logic [ClsW-1:0] classify(input logic [7:0] proto);
    logic [ClsW-1:0] c;
    priority if (proto == ProtoIcmp) c = ClsIcmp;
    else if (proto == ProtoTcp)      c = ClsTcp;
    else if (proto == ProtoUdp)      c = ClsUdp;
    else                             c = ClsOther;
    return c;
  endfunction

endpackage

`default_nettype wire

// File: rtl/flow_v1_record_decoder.sv
// Channel  Direction  Handshake            Payload
// in       input      in_valid_i/in_stall_o  in_item_i  (fv1rd_pkg::in_item_t)
// out      output     out_valid_o/out_stall_i out_item_o (fv1rd_pkg::out_item_t)
//
// One item per cycle while out_stall_i is low; front reg, then output reg.
// Accept stage reads the per-class counter RAM and forms the header products;
// next stage updates state, writes the RAM and loads the output register.
// RAM write-to-read overlap is covered by a one-entry forward register.
// Reset clears header state, totals and RAM valid bits; no clearing pass.
// in_stall_o rises only when both stages hold items and the output is stalled.
`default_nettype none

module flow_v1_record_decoder (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  fv1rd_pkg::in_item_t  in_item_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output fv1rd_pkg::out_item_t out_item_o
);
  import fv1rd_pkg::*;

  front_t          s1;
  logic            accept;
  logic            s1_adv;
  logic            s1_fire;

  cnt_t            rd_data;
  cnt_t            cur;
  cnt_t            nxt;
  logic            cnt_we;

  logic            fwd_vld_q;
  logic [ClsW-1:0] fwd_cls_q;
  cnt_t            fwd_q;

  logic [63:0]     boot_q, boot_d;
  logic [31:0]     hup_q, hup_d;
  logic [RecW-1:0] rl_q, rl_d;
  cnt_t            tot_q, tot_d;

  logic            out_valid_q;
  out_item_t       out_q, out_d;

  logic            wrap_first;
  logic            wrap_last;
  logic [31:0]     start_hi;
  logic [31:0]     end_hi;
  logic [15:0]     sp, dp;

  assign s1_adv     = !out_valid_q || !out_stall_i;
  assign in_stall_o = s1.valid && !s1_adv;
  assign accept     = in_valid_i && !in_stall_o;
  assign s1_fire    = s1.valid && s1_adv;

  fv1rd_front u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .accept_i  (accept),
    .advance_i (s1_adv),
    .item_i    (in_item_i),
    .stage_o   (s1)
  );

  fv1rd_cnt_mem u_cnt_mem (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_en_i   (accept),
    .rd_addr_i (classify(in_item_i.ip_protocol)),
    .wr_en_i   (cnt_we),
    .wr_addr_i (s1.cls),
    .wr_data_i (nxt),
    .rd_data_o (rd_data)
  );

  assign cur = (fwd_vld_q && fwd_cls_q == s1.cls) ? fwd_q : rd_data;

  assign wrap_first = s1.item.first_uptime > s1.item.last_uptime;
  assign wrap_last  = s1.item.last_uptime > hup_q;
  assign start_hi   = 32'd0 - 32'(wrap_first) - 32'(wrap_last);
  assign end_hi     = 32'd0 - 32'(wrap_last);

  always_comb begin
    sp = s1.item.source_port;
    dp = s1.item.dest_port;
    if (s1.cls == ClsIcmp && sp != 16'd0) begin
      dp = {sp[7:0], sp[15:8]};
      sp = 16'd0;
    end
  end

  always_comb begin
    boot_d = boot_q;
    hup_d  = hup_q;
    rl_d   = rl_q;
    tot_d  = tot_q;
    cnt_we = 1'b0;
    out_d  = '0;
    nxt.flows   = cur.flows + 64'd1;
    nxt.packets = cur.packets + 64'(s1.item.packet_total);
    nxt.bytes   = cur.bytes + 64'(s1.item.octet_total);
    if (s1_fire) begin
      unique case (s1.item.action)
        ActHeader: begin
          if (s1.item.record_count > 16'(MaxRecords)) begin
            rl_d         = '0;
            out_d.status = StHdrRej;
          end else begin
            boot_d = 64'(s1.secs_ms) + 64'(s1.nanos_ms) - 64'(s1.item.uptime_ms);
            hup_d  = s1.item.uptime_ms;
            rl_d   = s1.item.record_count[RecW-1:0];
            out_d.status = StHdrOk;
          end
        end
        ActRecord: begin
          if (rl_q == '0) begin
            out_d.status = StRecDrop;
          end else begin
            rl_d          = rl_q - RecW'(1);
            cnt_we        = 1'b1;
            tot_d.flows   = tot_q.flows + 64'd1;
            tot_d.packets = tot_q.packets + 64'(s1.item.packet_total);
            tot_d.bytes   = tot_q.bytes + 64'(s1.item.octet_total);
            out_d.status        = StRecOk;
            out_d.start_ms      = boot_q + {start_hi, s1.item.first_uptime};
            out_d.end_ms        = boot_q + {end_hi, s1.item.last_uptime};
            out_d.out_src_port  = sp;
            out_d.out_dst_port  = dp;
            out_d.proto_class   = s1.cls;
            out_d.class_flows   = nxt.flows;
            out_d.class_packets = nxt.packets;
            out_d.class_bytes   = nxt.bytes;
            out_d.all_flows     = tot_d.flows;
            out_d.all_packets   = tot_d.packets;
            out_d.all_bytes     = tot_d.bytes;
          end
        end
        default: out_d.status = StRecDrop;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      boot_q      <= '0;
      hup_q       <= '0;
      rl_q        <= '0;
      tot_q       <= '0;
      fwd_vld_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      boot_q <= boot_d;
      hup_q  <= hup_d;
      rl_q   <= rl_d;
      tot_q  <= tot_d;
      if (cnt_we) begin
        fwd_vld_q <= 1'b1;
      end
      if (s1_adv) begin
        out_valid_q <= s1.valid;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cnt_we) begin
      fwd_cls_q <= s1.cls;
      fwd_q     <= nxt;
    end
    if (s1_fire) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (out_valid_q && out_stall_i && s1.valid))
    else $error("input stalled without a full pipeline");

  a_total_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_we |=> (tot_q.flows == $past(tot_q.flows) + 64'd1))
    else $error("total flow count did not step by one");

  a_fwd_track: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_we |=> (fwd_vld_q && fwd_cls_q == $past(s1.cls)))
    else $error("forward register missed a counter write");

  a_rec_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_fire && s1.item.action == ActRecord && rl_q != '0)
      |=> (rl_q == $past(rl_q) - RecW'(1)))
    else $error("records left not decremented");

  a_we_fire: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_we |-> (s1_fire && s1.item.action == ActRecord))
    else $error("counter write without a converted record");

endmodule

`default_nettype wire

// File: rtl/fv1rd_front.sv
`default_nettype none

module fv1rd_front (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               accept_i,
  input  logic               advance_i,
  input  fv1rd_pkg::in_item_t item_i,
  output fv1rd_pkg::front_t  stage_o
);
  import fv1rd_pkg::*;

  logic                valid_q, valid_d;
  in_item_t            item_q;
  logic [ClsW-1:0]     cls_q;
  logic [SecsMsW-1:0]  secs_ms_q;
  logic [NanosMsW-1:0] nanos_ms_q;
  logic [52:0]         ns_prod;
  logic [SecsMsW-1:0]  secs_prod;

  assign ns_prod   = 53'(item_i.epoch_nanos[31:6]) * 53'(NsDivMul);
  assign secs_prod = SecsMsW'(item_i.epoch_secs) * SecsMsW'(MsPerSec);

  always_comb begin
    priority if (accept_i) valid_d = 1'b1;
    else if (advance_i)    valid_d = 1'b0;
    else                   valid_d = valid_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept_i) begin
      item_q     <= item_i;
      cls_q      <= classify(item_i.ip_protocol);
      secs_ms_q  <= secs_prod;
      nanos_ms_q <= ns_prod[NsDivShift +: NanosMsW];
    end
  end

  assign stage_o.valid    = valid_q;
  assign stage_o.item     = item_q;
  assign stage_o.cls      = cls_q;
  assign stage_o.secs_ms  = secs_ms_q;
  assign stage_o.nanos_ms = nanos_ms_q;

endmodule

`default_nettype wire

// File: rtl/fv1rd_cnt_mem.sv
`default_nettype none

module fv1rd_cnt_mem (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        rd_en_i,
  input  logic [fv1rd_pkg::ClsW-1:0]  rd_addr_i,
  input  logic                        wr_en_i,
  input  logic [fv1rd_pkg::ClsW-1:0]  wr_addr_i,
  input  fv1rd_pkg::cnt_t             wr_data_i,
  output fv1rd_pkg::cnt_t             rd_data_o
);
  import fv1rd_pkg::*;

  cnt_t              mem [NumCls];
  logic [NumCls-1:0] vld_q;
  cnt_t              rd_q;
  logic              rd_vld_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_q <= mem[rd_addr_i];
    end
  end

  // entries read as zero until first written
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q    <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      if (wr_en_i) begin
        vld_q[wr_addr_i] <= 1'b1;
      end
      if (rd_en_i) begin
        rd_vld_q <= vld_q[rd_addr_i];
      end
    end
  end

  assign rd_data_o = rd_vld_q ? rd_q : '0;

endmodule

`default_nettype wire
